// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/ppm_pkg.sv =====
package ppm_pkg;

   localparam int DEF_MAX_CHANNELS  = 8;
   localparam int DEF_SAMPLE_BITS   = 24;
   localparam int DEF_LOG_FRAC_BITS = 6;

   localparam int COEF_BITS   = 24;
   localparam int FLOOR_BITS  = 23;
   localparam int CH_W        = 3;
   localparam int DB_W        = 16;
   localparam int LOG_Q_BITS  = 16;
   localparam int FRONT_DEPTH = 4;
   localparam int OUT_DEPTH   = 8;

   localparam logic [COEF_BITS-1:0]  ATTACK_RESET  = 24'd83886;
   localparam logic [COEF_BITS-1:0]  RELEASE_RESET = 24'd513;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET   = 23'd56522;

   // 20*log10(2) in Q.16
   localparam int                DB_K_BITS   = 19;
   localparam logic [DB_K_BITS-1:0] DB_PER_LOG2 = 19'd394566;

   typedef enum logic [1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_RELEASE = 2'd1,
      CSR_FLOOR   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COEF_BITS-1:0]  atk_coeff;
      logic [COEF_BITS-1:0]  rel_coeff;
      logic [FLOOR_BITS-1:0] peak_floor;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0]        channel;
      logic signed [DB_W-1:0] peak_db;
   } res_type;

   // log2 fraction of (1 + idx/2^frac_bits), Q0.16, by repeated squaring
   function automatic logic [LOG_Q_BITS-1:0] ppm_log_frac(int unsigned idx,
                                                          int unsigned frac_bits);
      logic [63:0]           m;
      logic [LOG_Q_BITS-1:0] f;
      m = ((64'd1 << frac_bits) | 64'(idx)) << (30 - frac_bits);
      f = '0;
      for (int b = LOG_Q_BITS - 1; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            f[b] = 1'b1;
            m    = m >> 1;
         end
      end
      return f;
   endfunction

endpackage

// ===== hw/rtl/ppm_fifo.sv =====
module ppm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ppm_front.sv =====
module ppm_front import ppm_pkg::*; #(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   localparam int CMD_W = CH_W + 1 + SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [CH_W-1:0]        req_channel,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_block_end,
   output logic                   req_full,
   input  logic                   q_pop,
   output logic                   q_empty,
   output logic [CMD_W-1:0]       q_data
);

   logic [SAMPLE_BITS-1:0] mag;
   logic                   chan_ok;
   logic                   q_push;
   logic                   q_full;

   // two's complement magnitude; most negative sample maps to full scale
   assign mag     = req_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~req_sample + 1'b1)
                                              : req_sample;
   assign chan_ok = ({29'd0, req_channel} < 32'(MAX_CHANNELS));
   assign q_push  = req_push & ~q_full & chan_ok;
   assign req_full = q_full;

   ppm_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (FRONT_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({req_channel, req_block_end, mag}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

endmodule

// ===== hw/rtl/ppm_back.sv =====
module ppm_back import ppm_pkg::*; #(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   localparam int CMD_W = CH_W + 1 + SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   q_empty,
   input  logic [CMD_W-1:0]       q_data,
   output logic                   q_pop,
   input  logic                   rsp_fire,
   output logic                   db_vld,
   output logic [CH_W-1:0]        db_ch,
   output logic [SAMPLE_BITS-1:0] db_peak
);

   localparam int SB      = SAMPLE_BITS;
   localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PW      = COEF_BITS + SB;
   localparam int CRW     = $clog2(OUT_DEPTH + 1);

   // per-channel {peak, envelope}
   logic [2*SB-1:0]         mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] wr_seen_ff, wr_seen_in;

   logic [CH_W-1:0]         q_ch;
   logic                    q_end;
   logic [SB-1:0]           q_mag;
   logic [CH_BITS+CH_W-1:0] q_ch_ext;
   logic [CH_BITS-1:0]      q_addr;

   logic                    e_vld_ff, e_vld_in;
   logic [CH_W-1:0]         e_ch_ff;
   logic                    e_end_ff;
   logic [SB-1:0]           e_mag_ff;
   logic [2*SB-1:0]         e_rd_ff;
   logic                    e_seen_ff;
   logic [CH_BITS+CH_W-1:0] e_ch_ext;
   logic [CH_BITS-1:0]      e_addr;

   logic                    last_vld_ff, last_vld_in;
   logic [CH_BITS-1:0]      last_addr_ff;
   logic [SB-1:0]           last_env_ff;
   logic [SB-1:0]           last_peak_ff;

   logic [CRW-1:0]          credits_ff, credits_in;
   logic                    credit_ok;

   logic                    fwd;
   logic [SB-1:0]           env_cur, peak_cur;
   logic                    attack;
   logic [COEF_BITS-1:0]    coef;
   logic [SB-1:0]           oper;
   logic [PW-1:0]           prod, prod_up;
   logic [SB-1:0]           env_new, peak_new, peak_wr;
   logic                    fire;

   assign q_ch     = q_data[CMD_W-1 -: CH_W];
   assign q_end    = q_data[SB];
   assign q_mag    = q_data[SB-1:0];
   assign q_ch_ext = {{CH_BITS{1'b0}}, q_ch};
   assign q_addr   = q_ch_ext[CH_BITS-1:0];
   assign e_ch_ext = {{CH_BITS{1'b0}}, e_ch_ff};
   assign e_addr   = e_ch_ext[CH_BITS-1:0];

   assign credit_ok = (credits_ff < CRW'(OUT_DEPTH));
   assign fire      = e_vld_ff & (~e_end_ff | credit_ok);
   assign q_pop     = ~q_empty & (~e_vld_ff | fire);

   // last write bypasses a read taken at the same edge
   assign fwd = last_vld_ff & (last_addr_ff == e_addr);

   always_comb begin
      if (fwd) begin
         env_cur  = last_env_ff;
         peak_cur = last_peak_ff;
      end else if (e_seen_ff) begin
         env_cur  = e_rd_ff[SB-1:0];
         peak_cur = e_rd_ff[2*SB-1:SB];
      end else begin
         env_cur  = '0;
         peak_cur = '0;
      end
   end

   // attack: env + a*(m-env) >> 24;  release: env - ceil(r*env >> 24)
   assign attack  = ~(env_cur > e_mag_ff);
   assign coef    = attack ? cfg.atk_coeff : cfg.rel_coeff;
   assign oper    = attack ? SB'(e_mag_ff - env_cur) : env_cur;
   assign prod    = PW'(coef) * PW'(oper);
   assign prod_up = prod + PW'({COEF_BITS{1'b1}});
   assign env_new = attack ? SB'(env_cur + prod[PW-1:COEF_BITS])
                           : SB'(env_cur - prod_up[PW-1:COEF_BITS]);
   assign peak_new = (env_new > peak_cur) ? env_new : peak_cur;
   assign peak_wr  = e_end_ff ? '0 : peak_new;

   assign db_vld  = fire & e_end_ff;
   assign db_ch   = e_ch_ff;
   assign db_peak = peak_new;

   always_comb begin
      e_vld_in    = q_pop ? 1'b1 : (fire ? 1'b0 : e_vld_ff);
      last_vld_in = last_vld_ff | fire;
      wr_seen_in  = wr_seen_ff;
      if (fire) begin
         wr_seen_in[e_addr] = 1'b1;
      end
      credits_in = credits_ff;
      case ({db_vld, rsp_fire})
         2'b10:   credits_in = CRW'(credits_ff + 1'b1);
         2'b01:   credits_in = CRW'(credits_ff - 1'b1);
         default: credits_in = credits_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff    <= 1'b0;
         last_vld_ff <= 1'b0;
         wr_seen_ff  <= '0;
         credits_ff  <= '0;
      end else begin
         e_vld_ff    <= e_vld_in;
         last_vld_ff <= last_vld_in;
         wr_seen_ff  <= wr_seen_in;
         credits_ff  <= credits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_ch_ff   <= q_ch;
         e_end_ff  <= q_end;
         e_mag_ff  <= q_mag;
         e_rd_ff   <= mem[q_addr];
         e_seen_ff <= wr_seen_ff[q_addr];
      end
      if (fire) begin
         mem[e_addr]  <= {peak_wr, env_new};
         last_addr_ff <= e_addr;
         last_env_ff  <= env_new;
         last_peak_ff <= peak_wr;
      end
   end

endmodule

// ===== hw/rtl/ppm_db.sv =====
module ppm_db import ppm_pkg::*; #(
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [FLOOR_BITS-1:0]  peak_floor,
   input  logic                   in_vld,
   input  logic [CH_W-1:0]        in_ch,
   input  logic [SAMPLE_BITS-1:0] in_peak,
   output logic                   out_vld,
   output res_type                out_res
);

   localparam int SB    = SAMPLE_BITS;
   localparam int LFB   = LOG_FRAC_BITS;
   localparam int TSIZE = 1 << LFB;
   localparam int CW    = (SB > FLOOR_BITS) ? SB : FLOOR_BITS;
   localparam int KW    = $clog2(SB);
   localparam int MW    = KW + LOG_Q_BITS;
   localparam int PRW   = MW + DB_K_BITS;
   localparam int QW    = PRW + 1 - 24;

   logic [LOG_Q_BITS-1:0] log_tab [TSIZE];

   for (genvar i = 0; i < TSIZE; i++) begin : g_tab
      assign log_tab[i] = ppm_log_frac(i, LFB);
   end

   logic [4:0]      vld_ff, vld_in;
   logic [CH_W-1:0] ch_ff [5];

   logic [SB-1:0]   s0_peak_ff;
   logic [SB-1:0]   s1_p_ff, s1_p_in;
   logic [SB-1:0]   s2_p_ff;
   logic [KW-1:0]   s2_k_ff, s2_k_in;
   logic [MW-1:0]   s3_mag_ff, s3_mag_in;
   logic [PRW-1:0]  s4_prod_ff, s4_prod_in;

   logic [FLOOR_BITS-1:0] fl;
   logic [CW-1:0]         mx;
   logic [SB+LFB-1:0]     sh;
   logic [LFB-1:0]        idx;
   logic [PRW:0]          rnd;
   logic [QW-1:0]         q;
   logic [16:0]           qs;

   // floor, then clamp to full scale
   assign fl = (peak_floor == '0) ? FLOOR_BITS'(1) : peak_floor;
   always_comb begin
      mx = (CW'(s0_peak_ff) < CW'(fl)) ? CW'(fl) : CW'(s0_peak_ff);
      if (mx > (CW'(1) << (SB - 1))) begin
         mx = CW'(1) << (SB - 1);
      end
      s1_p_in = mx[SB-1:0];
   end

   // leading one position
   always_comb begin
      s2_k_in = '0;
      for (int i = 0; i < SB; i++) begin
         if (s1_p_ff[i]) begin
            s2_k_in = KW'(i);
         end
      end
   end

   // bits below the leading one index the fraction table
   assign sh        = {s2_p_ff, {LFB{1'b0}}} >> s2_k_ff;
   assign idx       = sh[LFB-1:0];
   assign s3_mag_in = {KW'(SB - 1) - s2_k_ff, {LOG_Q_BITS{1'b0}}} - MW'(log_tab[idx]);

   assign s4_prod_in = PRW'(s3_mag_ff) * PRW'(DB_PER_LOG2);

   assign rnd = (PRW+1)'(s4_prod_ff) + ((PRW+1)'(1) << 23);
   assign q   = rnd[PRW:24];
   assign qs  = (32'(q) > 32'd32768) ? 17'd32768 : 17'(q);

   assign out_vld         = vld_ff[4];
   assign out_res.channel = ch_ff[4];
   assign out_res.peak_db = DB_W'(17'd0 - qs);

   assign vld_in = {vld_ff[3:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff[0]   <= in_ch;
      for (int i = 1; i < 5; i++) begin
         ch_ff[i] <= ch_ff[i-1];
      end
      s0_peak_ff <= in_peak;
      s1_p_ff    <= s1_p_in;
      s2_p_ff    <= s1_p_ff;
      s2_k_ff    <= s2_k_in;
      s3_mag_ff  <= s3_mag_in;
      s4_prod_ff <= s4_prod_in;
   end

endmodule

// ===== hw/rtl/peak_program_meter_top.sv =====
// Peak program meter. Each transaction is one signed sample of one channel;
// the channel's envelope follows the sample magnitude (attack when rising,
// release decay when falling) and the block peak holds the envelope's
// maximum. A sample flagged block_end produces one result: the floored peak
// in dBFS (Q8.8), after which that channel's peak restarts from zero while
// its envelope carries on. Samples for a channel at or above MAX_CHANNELS
// are taken and dropped. One sample is taken every clock cycle; the envelope
// update (one multiply and add) in the back end forwards its last write so
// the same channel may repeat on every cycle. A result passes the envelope
// stage and the dB stages s0 to s4, then waits in an eight-entry result
// queue; input stalls only when that queue backs up.
// Per-channel state is valid right after reset with no clearing pass.
// Coefficient writes are meant to happen while no transaction is in flight.
module peak_program_meter_top import ppm_pkg::*; #(
   parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [CH_W-1:0]        req_channel,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_block_end,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CH_W-1:0]        rsp_out_channel,
   output logic signed [DB_W-1:0] rsp_peak_db,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [COEF_BITS-1:0]   csr_wdata
);

`include "assert_macros.svh"

   localparam int CMD_W = CH_W + 1 + SAMPLE_BITS;
   localparam int RES_W = $bits(res_type);

   cfg_type cfg_ff, cfg_in;

   logic                   q_empty, q_pop;
   logic [CMD_W-1:0]       q_data;
   logic                   db_vld;
   logic [CH_W-1:0]        db_ch;
   logic [SAMPLE_BITS-1:0] db_peak;
   logic                   res_push, res_full;
   res_type                res_in, res_out;
   logic [RES_W-1:0]       res_out_bits;
   logic                   rsp_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATTACK:  cfg_in.atk_coeff  = csr_wdata;
            CSR_RELEASE: cfg_in.rel_coeff  = csr_wdata;
            CSR_FLOOR:   cfg_in.peak_floor = csr_wdata[FLOOR_BITS-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.atk_coeff  <= ATTACK_RESET;
         cfg_ff.rel_coeff  <= RELEASE_RESET;
         cfg_ff.peak_floor <= FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppm_front #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_channel   (req_channel),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .req_full      (req_full),
      .q_pop         (q_pop),
      .q_empty       (q_empty),
      .q_data        (q_data)
   );

   assign rsp_fire = rsp_pop & ~rsp_empty;

   ppm_back #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .rsp_fire (rsp_fire),
      .db_vld   (db_vld),
      .db_ch    (db_ch),
      .db_peak  (db_peak)
   );

   ppm_db #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .LOG_FRAC_BITS (LOG_FRAC_BITS)
   ) u_db (
      .clock      (clock),
      .reset      (reset),
      .peak_floor (cfg_ff.peak_floor),
      .in_vld     (db_vld),
      .in_ch      (db_ch),
      .in_peak    (db_peak),
      .out_vld    (res_push),
      .out_res    (res_in)
   );

   ppm_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out_bits),
      .empty     (rsp_empty)
   );

   assign res_out         = res_type'(res_out_bits);
   assign rsp_out_channel = res_out.channel;
   assign rsp_peak_db     = res_out.peak_db;

   // credit scheme must keep room for every result in flight
   `ASSERT_IMPL(a_res_room, clock, reset, res_push, !res_full)
   `ASSERT_NEXT(a_res_shows, clock, reset, res_push, !rsp_empty)
   `ASSERT_IMPL(a_cmd_pop, clock, reset, q_pop, !q_empty)

endmodule
